>>> hw/rtl/four_queue_round_robin_merge_macros.svh
// Assertion macros shared by the merge block.
`ifndef FOUR_QUEUE_ROUND_ROBIN_MERGE_MACROS_SVH
`define FOUR_QUEUE_ROUND_ROBIN_MERGE_MACROS_SVH

`ifndef NO_ASSERTIONS
// ante holds in a cycle, cons must hold in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// ante holds in a cycle, cons must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/fqrr_pkg.sv
`default_nettype none

package fqrr_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = 4;
    localparam int QSEL_W     = 2;
    localparam int ADDR_W     = QSEL_W + SLOT_W;
    localparam int TAG_W      = 32;
    localparam int DIR_W      = 3;
    localparam int ACT_W      = 2;
    localparam int CNT_W      = 5;
    localparam int TOTAL_W    = 7;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_LVL_W = 2;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_LVL_W  = 3;

    localparam logic [ACT_W-1:0] ACT_SELECT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DRAIN  = 2'd2;

    localparam logic [DIR_W-1:0] DIR_MIN = 3'd1;
    localparam logic [DIR_W-1:0] DIR_MAX = 3'd4;

    typedef enum logic [1:0] {
        CMD_SELECT,
        CMD_PUSH,
        CMD_DRAIN
    } cmd_kind_t;

    typedef enum logic {
        EXEC_IDLE,
        EXEC_DRAIN
    } exec_state_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [DIR_W-1:0] direction;
        logic [TAG_W-1:0] item_tag;
    } in_item_t;

    typedef struct packed {
        logic [TAG_W-1:0] out_tag;
        logic [DIR_W-1:0] from_queue;
        logic             valid_res;
        logic             last;
        logic             overflow;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [QSEL_W-1:0] qsel;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic [DIR_W-1:0] from_queue;
        logic             valid_res;
        logic             last;
        logic             overflow;
    } res_meta_t;

    typedef struct packed {
        logic [OUT_LVL_W-1:0] level;
        logic                 popping;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic last_step;
    } exec_stat_t;

    // Drain visits directions 1, 3, 2, 4.
    function automatic logic [QSEL_W-1:0] visit_queue(input logic [QSEL_W-1:0] pos);
        logic [QSEL_W-1:0] q;
        unique case (pos)
            2'd0:    q = 2'd0;
            2'd1:    q = 2'd2;
            2'd2:    q = 2'd1;
            default: q = 2'd3;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fqrr_in_if.sv
`default_nettype none

interface fqrr_in_if
    import fqrr_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fqrr_out_if.sv
`default_nettype none

interface fqrr_out_if
    import fqrr_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fqrr_front.sv
`default_nettype none

module fqrr_front
    import fqrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fqrr_in_if.sink    items,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_ready
);

    cmd_t                  q_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_LVL_W-1:0] level_reg;

    cmd_t cmd_in;
    logic keep;
    logic push;
    logic pop;

    // Classify: drop unused codes and selects outside the direction range.
    always_comb
    begin
        keep        = 1'b0;
        cmd_in.kind = CMD_SELECT;
        cmd_in.qsel = QSEL_W'(items.data.direction - DIR_MIN);
        cmd_in.tag  = items.data.item_tag;
        unique case (items.data.action)
            ACT_SELECT:
            begin
                keep = (items.data.direction >= DIR_MIN) && (items.data.direction <= DIR_MAX);
            end
            ACT_PUSH:
            begin
                cmd_in.kind = CMD_PUSH;
                keep        = 1'b1;
            end
            ACT_DRAIN:
            begin
                cmd_in.kind = CMD_DRAIN;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign items.ready = (level_reg != CMDQ_LVL_W'(CMDQ_DEPTH));
    assign push        = items.valid && items.ready && keep;
    assign cmd_valid   = (level_reg != '0);
    assign cmd         = q_mem[rd_ptr_reg];
    assign pop         = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            end
            level_reg <= level_reg + CMDQ_LVL_W'(push) - CMDQ_LVL_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fqrr_exec.sv
`default_nettype none

module fqrr_exec
    import fqrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_ready,
    input  fifo_stat_t fifo_stat,
    output logic       res_valid,
    output out_item_t  res,
    output exec_stat_t exec_stat
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);

    exec_state_t         state_reg;
    exec_state_t         state_next;
    logic                dir_vld_reg;
    logic [QSEL_W-1:0]   dir_q_reg;
    logic                ovf_reg;
    logic [SLOT_W-1:0]   head_reg  [NUM_QUEUES];
    logic [CNT_W-1:0]    count_reg [NUM_QUEUES];
    logic [QSEL_W-1:0]   pos_reg;
    logic [TOTAL_W-1:0]  remain_reg;
    logic                pipe_vld_reg;
    res_meta_t           meta_reg;
    logic [TAG_W-1:0]    rd_data_reg;
    logic [TAG_W-1:0]    mem [NUM_QUEUES * SLOTS];

    logic [NUM_QUEUES-1:0] nonempty;
    logic [TOTAL_W-1:0]    total;
    logic [OUT_LVL_W:0]    lvl_ahead;
    logic                  can_issue;
    logic [QSEL_W-1:0]     pick_pos;
    logic [QSEL_W-1:0]     pick_q;
    logic [QSEL_W-1:0]     sel_q;
    logic [SLOT_W-1:0]     sel_head;
    logic [CNT_W-1:0]      sel_count;
    logic [CNT_W:0]        slot_sum;
    logic [CNT_W:0]        slot_wrap;
    logic [CNT_W-1:0]      head_inc;
    logic [SLOT_W-1:0]     head_next;
    logic                  push_full;
    logic                  push_write;
    logic                  last_step;

    logic do_select;
    logic do_push;
    logic start_drain;
    logic issue_empty;
    logic drain_step;

    always_comb
    begin
        total = '0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            nonempty[q] = (count_reg[q] != '0);
            total       = total + TOTAL_W'(count_reg[q]);
        end
    end

    // Results already queued or in the read stage must leave room for one more.
    assign lvl_ahead = (OUT_LVL_W + 1)'(fifo_stat.level) + (OUT_LVL_W + 1)'(pipe_vld_reg)
                       - (OUT_LVL_W + 1)'(fifo_stat.popping);
    assign can_issue = (lvl_ahead < (OUT_LVL_W + 1)'(OUT_DEPTH));

    // First non-empty queue from the current visit position, wrapping into the next round.
    always_comb
    begin
        logic [QSEL_W-1:0] p;
        logic              found;
        found    = 1'b0;
        pick_pos = pos_reg;
        p        = pos_reg;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            p = pos_reg + QSEL_W'(i);
            if (!found && nonempty[visit_queue(p)])
            begin
                found    = 1'b1;
                pick_pos = p;
            end
        end
    end

    assign pick_q    = visit_queue(pick_pos);
    assign sel_q     = (state_reg == EXEC_DRAIN) ? pick_q : dir_q_reg;
    assign sel_head  = head_reg[sel_q];
    assign sel_count = count_reg[sel_q];

    assign slot_sum  = (CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_count);
    assign slot_wrap = (slot_sum >= DEPTH_SUM) ? (slot_sum - DEPTH_SUM) : slot_sum;
    assign head_inc  = CNT_W'(sel_head) + CNT_W'(1);
    assign head_next = (head_inc == DEPTH_CNT) ? '0 : head_inc[SLOT_W-1:0];
    assign push_full = (sel_count >= DEPTH_CNT);

    // Command decisions
    always_comb
    begin
        cmd_ready   = 1'b0;
        do_select   = 1'b0;
        do_push     = 1'b0;
        start_drain = 1'b0;
        issue_empty = 1'b0;
        drain_step  = 1'b0;
        unique case (state_reg)
            EXEC_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_SELECT:
                        begin
                            cmd_ready = 1'b1;
                            do_select = 1'b1;
                        end
                        CMD_PUSH:
                        begin
                            cmd_ready = 1'b1;
                            do_push   = 1'b1;
                        end
                        CMD_DRAIN:
                        begin
                            if (total != '0)
                            begin
                                cmd_ready   = 1'b1;
                                start_drain = 1'b1;
                            end
                            else if (can_issue)
                            begin
                                cmd_ready   = 1'b1;
                                issue_empty = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            EXEC_DRAIN:
            begin
                drain_step = can_issue;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign last_step  = drain_step && (remain_reg == TOTAL_W'(1));
    assign push_write = do_push && dir_vld_reg && !push_full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EXEC_IDLE:
            begin
                if (start_drain)
                begin
                    state_next = EXEC_DRAIN;
                end
            end
            EXEC_DRAIN:
            begin
                if (last_step)
                begin
                    state_next = EXEC_IDLE;
                end
            end
            default:
            begin
                state_next = EXEC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= EXEC_IDLE;
            dir_vld_reg  <= 1'b0;
            dir_q_reg    <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            remain_reg   <= '0;
            pipe_vld_reg <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q]  <= '0;
                count_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= drain_step || issue_empty;
            if (do_select)
            begin
                dir_vld_reg <= 1'b1;
                dir_q_reg   <= cmd.qsel;
            end
            if (do_push && dir_vld_reg)
            begin
                if (push_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg[sel_q] <= sel_count + CNT_W'(1);
                end
            end
            if (start_drain)
            begin
                remain_reg <= total;
                pos_reg    <= '0;
            end
            if (drain_step)
            begin
                remain_reg       <= remain_reg - TOTAL_W'(1);
                pos_reg          <= pick_pos + QSEL_W'(1);
                count_reg[sel_q] <= sel_count - CNT_W'(1);
                if (last_step)
                begin
                    // all queues are now empty: rewind every head
                    for (int q = 0; q < NUM_QUEUES; q++)
                    begin
                        head_reg[q] <= '0;
                    end
                end
                else
                begin
                    head_reg[sel_q] <= head_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_write)
        begin
            mem[{sel_q, slot_wrap[SLOT_W-1:0]}] <= cmd.tag;
        end
        if (drain_step)
        begin
            rd_data_reg <= mem[{sel_q, sel_head}];
        end
        if (drain_step || issue_empty)
        begin
            meta_reg.from_queue <= drain_step ? (DIR_W'(pick_q) + DIR_MIN) : '0;
            meta_reg.valid_res  <= drain_step;
            meta_reg.last       <= issue_empty || last_step;
            meta_reg.overflow   <= ovf_reg;
        end
    end

    assign res_valid      = pipe_vld_reg;
    assign res.out_tag    = meta_reg.valid_res ? rd_data_reg : '0;
    assign res.from_queue = meta_reg.from_queue;
    assign res.valid_res  = meta_reg.valid_res;
    assign res.last       = meta_reg.last;
    assign res.overflow   = meta_reg.overflow;

    assign exec_stat.busy      = (state_reg == EXEC_DRAIN);
    assign exec_stat.last_step = last_step;

endmodule

`default_nettype wire

>>> hw/rtl/fqrr_out_fifo.sv
`default_nettype none

module fqrr_out_fifo
    import fqrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_valid,
    input  out_item_t   wr_item,
    fqrr_out_if.source  results,
    output fifo_stat_t  fifo_stat
);

    out_item_t            buf_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_LVL_W-1:0] level_reg;
    logic                 pop;

    assign results.valid     = (level_reg != '0);
    assign results.data      = buf_mem[rd_ptr_reg];
    assign pop               = results.valid && results.ready;
    assign fifo_stat.level   = level_reg;
    assign fifo_stat.popping = pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            level_reg <= level_reg + OUT_LVL_W'(wr_valid) - OUT_LVL_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            buf_mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/four_queue_round_robin_merge.sv
// A new item is accepted every cycle while the front queue has room.
// Drain: results follow one per cycle while the output FIFO has room, set by the
// single tag store read port; the front queue takes at most two more items meanwhile.
// An empty drain gives its single result through the read stage and the output FIFO.
// Reset clears queue heads, counts, the direction and the overflow flag at once;
// the tag store is not cleared and needs no clearing pass.
`default_nettype none
`include "four_queue_round_robin_merge_macros.svh"

module four_queue_round_robin_merge
    import fqrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    fqrr_in_if.sink    items,
    fqrr_out_if.source results
);

    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_ready;
    fifo_stat_t fifo_stat;
    exec_stat_t exec_stat;
    logic       res_valid;
    out_item_t  res;

    fqrr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    fqrr_exec #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .fifo_stat (fifo_stat),
        .res_valid (res_valid),
        .res       (res),
        .exec_stat (exec_stat)
    );

    fqrr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_valid  (res_valid),
        .wr_item   (res),
        .results   (results),
        .fifo_stat (fifo_stat)
    );

    `ASSERT_IMPL(a_fifo_no_overrun, clk, rst_n, res_valid,
                 (fifo_stat.level != OUT_LVL_W'(OUT_DEPTH)) || fifo_stat.popping)
    `ASSERT_IMPL(a_empty_drain_form, clk, rst_n, results.valid && !results.data.valid_res,
                 results.data.last && (results.data.from_queue == '0))
    `ASSERT_NEXT(a_drain_returns_idle, clk, rst_n, exec_stat.last_step, !exec_stat.busy)
    `ASSERT_IMPL(a_no_cmd_while_drain, clk, rst_n, cmd_valid && cmd_ready, !exec_stat.busy)

endmodule

`default_nettype wire

>>> test/four_queue_round_robin_merge_tb.sv
`default_nettype none

module four_queue_round_robin_merge_tb
    import fqrr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 20;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [DIR_W-1:0] DIR_NONE   = 3'd0;

    // Merge order: directions 1, 3, 2, 4.
    localparam int ROUND_ORDER [NUM_QUEUES] = '{0, 2, 1, 3};

    class merge_scoreboard;
        logic [TAG_W-1:0] held_tags [NUM_QUEUES][SLOTS];
        int unsigned      head_slot [NUM_QUEUES];
        int unsigned      fill_level [NUM_QUEUES];
        logic [DIR_W-1:0] cur_dir;
        logic             overflow_seen;
        out_item_t        merged_pending [$];
        int unsigned      mismatches;
        int unsigned      drains;
        int unsigned      widest_drain;
        int unsigned      beats_checked;

        function new();
            foreach (held_tags[q, s])
                held_tags[q][s] = '0;
            foreach (head_slot[q])
            begin
                head_slot[q]  = 0;
                fill_level[q] = 0;
            end
            cur_dir       = DIR_NONE;
            overflow_seen = 1'b0;
            mismatches    = 0;
            drains        = 0;
            widest_drain  = 0;
            beats_checked = 0;
        endfunction

        // Fold one accepted input beat into the state and queue the merged results.
        function void note_item(in_item_t it);
            int unsigned q;
            int unsigned slot;
            int unsigned remaining;
            int unsigned emitted;
            out_item_t   r;
            if (it.action == ACT_SELECT)
            begin
                if (it.direction >= DIR_MIN && it.direction <= DIR_MAX)
                    cur_dir = it.direction;
            end
            else if (it.action == ACT_PUSH)
            begin
                if (cur_dir != DIR_NONE)
                begin
                    q = int'(cur_dir) - 1;
                    if (fill_level[q] >= QUEUE_DEPTH)
                        overflow_seen = 1'b1;
                    else
                    begin
                        slot = (head_slot[q] + fill_level[q]) % QUEUE_DEPTH;
                        held_tags[q][slot % SLOTS] = it.item_tag;
                        fill_level[q]++;
                    end
                end
            end
            else if (it.action == ACT_DRAIN)
            begin
                drains++;
                remaining = 0;
                foreach (fill_level[i])
                    remaining += fill_level[i];
                if (remaining == 0)
                begin
                    r.out_tag    = '0;
                    r.from_queue = DIR_NONE;
                    r.valid_res  = 1'b0;
                    r.last       = 1'b1;
                    r.overflow   = overflow_seen;
                    merged_pending.push_back(r);
                    if (widest_drain == 0)
                        widest_drain = 1;
                end
                else
                begin
                    emitted = 0;
                    while (remaining > 0)
                    begin
                        foreach (ROUND_ORDER[v])
                        begin
                            q = ROUND_ORDER[v];
                            if (fill_level[q] != 0)
                            begin
                                r.out_tag    = held_tags[q][head_slot[q] % SLOTS];
                                r.from_queue = DIR_W'(q + 1);
                                r.valid_res  = 1'b1;
                                head_slot[q] = (head_slot[q] + 1) % QUEUE_DEPTH;
                                fill_level[q]--;
                                remaining--;
                                r.last       = (remaining == 0);
                                r.overflow   = overflow_seen;
                                merged_pending.push_back(r);
                                emitted++;
                            end
                        end
                    end
                    if (emitted > widest_drain)
                        widest_drain = emitted;
                    foreach (head_slot[i])
                    begin
                        head_slot[i]  = 0;
                        fill_level[i] = 0;
                    end
                end
            end
        endfunction

        function void compare_field(string field, logic [TAG_W-1:0] want,
                                    logic [TAG_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            beats_checked++;
            if (merged_pending.size() == 0)
            begin
                $error("result beat with nothing pending: tag 0x%0h from %0d",
                       got.out_tag, got.from_queue);
                mismatches++;
                return;
            end
            want = merged_pending.pop_front();
            compare_field("out_tag", want.out_tag, got.out_tag);
            compare_field("from_queue", TAG_W'(want.from_queue), TAG_W'(got.from_queue));
            compare_field("valid_res", TAG_W'(want.valid_res), TAG_W'(got.valid_res));
            compare_field("last", TAG_W'(want.last), TAG_W'(got.last));
            compare_field("overflow", TAG_W'(want.overflow), TAG_W'(got.overflow));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fqrr_in_if  items_ch ();
    fqrr_out_if merged_ch ();

    four_queue_round_robin_merge #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_ch),
        .results(merged_ch)
    );

    merge_scoreboard board = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned beats_sent;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver back-pressure.
    initial
    begin
        merged_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            merged_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check result beats and watch for a hung handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (merged_ch.valid && merged_ch.ready)
                board.check_result(merged_ch.data);
            if ((merged_ch.valid && merged_ch.ready) || (items_ch.valid && items_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("no beat moved for %0d cycles, %0d results still pending",
                         STALL_LIMIT, board.merged_pending.size());
                $display("four_queue_round_robin_merge test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_item_t make_item(logic [ACT_W-1:0] action,
                                           logic [DIR_W-1:0] direction,
                                           logic [TAG_W-1:0] tag);
        in_item_t it;
        it.action    = action;
        it.direction = direction;
        it.item_tag  = tag;
        return it;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return TAG_W'($urandom);
    endfunction

    function automatic logic [DIR_W-1:0] any_dir();
        return DIR_W'($urandom);
    endfunction

    // Hold valid across back-to-back beats; drop it only for an idle gap.
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            items_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        items_ch.valid <= 1'b1;
        items_ch.data  <= it;
        do
            @(posedge clk);
        while (!items_ch.ready);
        board.note_item(it);
        beats_sent++;
    endtask

    task automatic send_drain();
        send_item(make_item(ACT_DRAIN, any_dir(), pick_tag()));
    endtask

    task automatic run_directed();
        // pushes before any select are dropped
        send_item(make_item(ACT_PUSH, DIR_MIN, 32'hDEAD_BEEF));
        send_item(make_item(ACT_SELECT, 3'd0, 32'h0));
        send_item(make_item(ACT_PUSH, DIR_MAX, 32'h1357_9BDF));
        send_item(make_item(ACT_UNUSED, 3'd7, '1));
        send_item(make_item(ACT_DRAIN, 3'd0, '0));
        send_item(make_item(ACT_SELECT, 3'd5, 32'h0));
        send_item(make_item(ACT_SELECT, 3'd7, '1));
        send_item(make_item(ACT_SELECT, 3'd1, 32'h0));
        send_item(make_item(ACT_PUSH, 3'd7, '1));
        send_item(make_item(ACT_PUSH, 3'd0, '0));
        send_item(make_item(ACT_SELECT, 3'd3, '1));
        send_item(make_item(ACT_PUSH, 3'd2, 32'h0000_0001));
        send_item(make_item(ACT_SELECT, 3'd2, 32'h0));
        send_item(make_item(ACT_PUSH, 3'd1, 32'h8000_0000));
        send_item(make_item(ACT_SELECT, 3'd4, 32'h0));
        send_item(make_item(ACT_PUSH, 3'd4, 32'hA5A5_A5A5));
        send_item(make_item(ACT_PUSH, 3'd6, 32'h5A5A_5A5A));
        // out-of-range select keeps direction 4
        send_item(make_item(ACT_SELECT, 3'd6, 32'h0));
        send_item(make_item(ACT_PUSH, 3'd5, 32'h0000_1234));
        send_item(make_item(ACT_DRAIN, 3'd3, 32'hFFFF_0000));
        send_item(make_item(ACT_DRAIN, 3'd0, '0));
        send_item(make_item(ACT_PUSH, 3'd0, 32'h0000_0077));
        send_item(make_item(ACT_DRAIN, 3'd7, '1));
    endtask

    // Fill all four queues past the top, then drain the full merge.
    task automatic run_full_merge(output int unsigned count);
        count = 0;
        for (int d = DIR_MIN; d <= DIR_MAX; d++)
        begin
            send_item(make_item(ACT_SELECT, DIR_W'(d), pick_tag()));
            repeat (QUEUE_DEPTH + 1)
                send_item(make_item(ACT_PUSH, any_dir(), pick_tag()));
            count += QUEUE_DEPTH + 2;
        end
        send_drain();
        count++;
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned done_items;
        int unsigned pick;
        int unsigned burst;
        int unsigned odd_dir;
        done_items = 0;
        while (done_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                send_item(make_item(ACT_SELECT, DIR_W'($urandom_range(DIR_MIN, DIR_MAX)),
                                    pick_tag()));
                burst = $urandom_range(1, 6);
                repeat (burst)
                    send_item(make_item(ACT_PUSH, any_dir(), pick_tag()));
                done_items += burst + 1;
                if ($urandom_range(99) < 35)
                begin
                    send_drain();
                    done_items++;
                end
            end
            else if (pick < 78)
            begin
                send_drain();
                done_items++;
            end
            else if (pick < 88)
            begin
                // noise the block ignores
                if ($urandom_range(1) == 0)
                    send_item(make_item(ACT_UNUSED, any_dir(), pick_tag()));
                else
                begin
                    odd_dir = $urandom_range(3);
                    send_item(make_item(ACT_SELECT,
                                        (odd_dir == 0) ? DIR_NONE : DIR_W'(odd_dir + 4),
                                        pick_tag()));
                end
            end
            else
            begin
                send_item(make_item(ACT_SELECT, any_dir(), pick_tag()));
                send_item(make_item(ACT_PUSH, any_dir(), pick_tag()));
                done_items += 2;
            end
        end
    endtask

    initial
    begin
        int unsigned full_count;
        rst_n          <= 1'b0;
        items_ch.valid <= 1'b0;
        items_ch.data  <= '0;
        quiet_cycles   = 0;
        beats_sent     = 0;
        send_idle_pct  = 24;
        recv_idle_pct  = 51;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(80);

        send_idle_pct = 51;
        recv_idle_pct = 24;
        run_full_merge(full_count);
        run_random((full_count < 90) ? 90 - full_count : 10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(90);

        items_ch.valid <= 1'b0;
        while (board.merged_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL)
            @(posedge clk);

        $display("sent %0d input beats including %0d drains; checked %0d merged beats",
                 beats_sent, board.drains, board.beats_checked);
        $display("widest drain %0d beats, overflow flag reached %0b",
                 board.widest_drain, board.overflow_seen);
        if (board.mismatches == 0)
            $display("four_queue_round_robin_merge test passed");
        else
            $display("four_queue_round_robin_merge test failed");
        $finish;
    end

endmodule

`default_nettype wire
